/* rtl/bgp_message_stream_parser_defines.svh */
// assertion macros for the bgp stream parser checker
// no dependencies
`ifndef BGP_MESSAGE_STREAM_PARSER_DEFINES_SVH
`define BGP_MESSAGE_STREAM_PARSER_DEFINES_SVH
`define BMP_ASSERT_IMPL(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) \
    else $error("check failed");
`define BMP_ASSERT_NEXT(label, clk, rst, a, c) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) \
    else $error("check failed");
`endif

/* rtl/bmp_pkg.sv */
// shared types and constants of the bgp stream parser
// no dependencies
package bmp_pkg;
  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_BAD_MARKER = 3'd1;
  localparam logic [2:0] ST_BAD_LENGTH = 3'd2;
  localparam logic [2:0] ST_TRUNCATED = 3'd3;
  localparam logic [2:0] ST_OVERRUN = 3'd4;
  localparam logic [2:0] ST_BAD_PREFIX = 3'd5;
  localparam logic [2:0] ST_IDLE_END = 3'd6;
  localparam logic [2:0] ST_BAD_VERSION = 3'd7;
  localparam logic [7:0] TYPE_OPEN = 8'd1;
  localparam logic [7:0] TYPE_UPDATE = 8'd2;
  localparam logic [7:0] TYPE_NOTIFICATION = 8'd3;
  localparam logic [15:0] HDR_LEN = 16'd19;
  localparam logic [15:0] MARKER_LEN = 16'd16;

  typedef struct packed {
    logic       req_type;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  msg_type;
    logic [2:0]  status;
    logic [15:0] msg_length;
    logic [15:0] withdrawn_total;
    logic [15:0] path_attr_len;
    logic [15:0] announced_count;
    logic        end_of_rib;
    logic [15:0] peer_as;
    logic [15:0] hold_time;
    logic [31:0] router_id;
    logic [7:0]  error_code;
    logic [7:0]  error_subcode;
  } out_item_t;
endpackage

/* rtl/bmp_stream_if.sv */
// valid/ready channel interface carrying one payload
// depends on nothing
interface bmp_stream_if #(parameter type payload_t = logic) (input logic clk);
  logic     valid;
  logic     ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

/* rtl/bmp_front.sv */
// front part: accepts input transfers and pushes them into the item queue, or drops them once halted
// depends on bmp_pkg
module bmp_front import bmp_pkg::*; (
  input  logic     in_valid,
  output logic     in_ready,
  input  in_item_t in_data,
  output logic     q_push,
  output in_item_t q_data,
  input  logic     q_full,
  input  logic     halted
);
  // once halted every input is swallowed
  assign in_ready = halted | ~q_full;
  assign q_push = in_valid & ~halted & ~q_full;
  assign q_data = in_data;
endmodule

/* rtl/bmp_queue.sv */
// two-entry item queue between front and back
// depends on bmp_pkg
module bmp_queue import bmp_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  in_item_t push_data,
  output logic     full,
  input  logic     pop,
  output logic     nonempty,
  output in_item_t pop_data
);
  in_item_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;
  assign full = cnt == 2'd2;
  assign nonempty = cnt != 2'd0;
  assign pop_data = mem[rp];
  always_ff @(posedge clk) begin
    if (push) mem[wp] <= push_data;
    if (rst) begin
      wp <= 1'b0;
      rp <= 1'b0;
      cnt <= 2'd0;
    end else begin
      if (push) wp <= ~wp;
      if (pop) rp <= ~rp;
      cnt <= cnt + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

/* rtl/bmp_back.sv */
// back part: byte-wise parse state and result register
// depends on bmp_pkg
module bmp_back import bmp_pkg::*; #(
  parameter int MAX_PREFIX_BITS = 32
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      q_nonempty,
  input  in_item_t  q_data,
  output logic      q_pop,
  output logic      halted,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);
  localparam int PBW = $clog2(MAX_PREFIX_BITS / 8 + 2);
  logic        phase;
  logic [15:0] pos, dlen, wlen, alen, wtally, ntally;
  logic [7:0]  ty;
  logic [PBW-1:0] pleft;
  logic [63:0] ofields;
  logic [2:0]  eflags;

  logic        phase_next;
  logic [15:0] pos_next, dlen_next, wlen_next, alen_next, wtally_next, ntally_next;
  logic [7:0]  ty_next;
  logic [PBW-1:0] pleft_next;
  logic [63:0] ofields_next;
  logic [2:0]  eflags_next;
  logic        halted_next, emit, clr;
  out_item_t   res;

  logic can_go;
  assign can_go = ~out_valid | out_ready;
  assign q_pop = q_nonempty & can_go & ~halted;

  function automatic out_item_t build(logic [2:0] st, logic ht, logic hl,
      logic [7:0] t, logic [15:0] l, logic [15:0] wt, logic [15:0] al,
      logic [15:0] nt, logic [63:0] of);
    out_item_t r;
    r = '0;
    r.status = st;
    if (hl) r.msg_length = l;
    if (ht) begin
      r.msg_type = t;
      if (t == TYPE_UPDATE) begin
        r.withdrawn_total = wt;
        r.path_attr_len = al;
        r.announced_count = nt;
        r.end_of_rib = hl && l == 16'd23;
      end else if (t == TYPE_OPEN) begin
        r.peer_as = of[63:48];
        r.hold_time = of[47:32];
        r.router_id = of[31:0];
      end else if (t == TYPE_NOTIFICATION) begin
        r.error_code = of[15:8];
        r.error_subcode = of[7:0];
      end
    end
    return r;
  endfunction

  always_comb begin
    logic [7:0]  b;
    logic [16:0] off, pl, wrl, tpal;
    logic [2:0]  ef;
    logic [15:0] wt, nt;
    logic [PBW-1:0] pbl;
    b = q_data.data_byte;
    phase_next = phase; pos_next = pos; dlen_next = dlen; wlen_next = wlen;
    alen_next = alen; wtally_next = wtally; ntally_next = ntally; ty_next = ty;
    pleft_next = pleft; ofields_next = ofields; eflags_next = eflags;
    halted_next = halted; emit = 1'b0; clr = 1'b0; res = '0;
    ef = '0; wt = wtally; nt = ntally; pbl = pleft;
    off = {1'b0, pos} - {1'b0, HDR_LEN};
    pl = {1'b0, dlen} - {1'b0, HDR_LEN};
    wrl = {1'b0, wlen};
    tpal = {1'b0, alen};
    if (q_data.req_type) begin
      emit = 1'b1; clr = 1'b1;
      if (!phase && pos == 16'd0) res = build(ST_IDLE_END, 1'b0, 1'b0, ty, dlen, '0, '0, '0, '0);
      else res = build(ST_TRUNCATED, phase, phase, ty, dlen, wtally, alen, ntally, ofields);
    end else if (!phase) begin
      pos_next = pos + 16'd1;
      if (pos < MARKER_LEN) begin
        if (b != 8'hFF) begin
          emit = 1'b1; clr = 1'b1; halted_next = 1'b1;
          res = build(ST_BAD_MARKER, 1'b0, 1'b0, ty, dlen, '0, '0, '0, '0);
        end
      end else if (pos == 16'd16) dlen_next = {b, 8'd0};
      else if (pos == 16'd17) dlen_next = {dlen[15:8], b};
      else begin
        ty_next = b;
        if (dlen < HDR_LEN) begin
          emit = 1'b1; clr = 1'b1;
          res = build(ST_BAD_LENGTH, 1'b1, 1'b1, b, dlen, '0, '0, '0, '0);
        end else if (dlen == HDR_LEN) begin
          ef = 3'd0;
          if (b == TYPE_UPDATE || b == TYPE_OPEN || b == TYPE_NOTIFICATION)
            ef = ST_OVERRUN;
          emit = 1'b1; clr = 1'b1;
          res = build(ef, 1'b1, 1'b1, b, dlen, '0, '0, '0, '0);
        end else phase_next = 1'b1;
      end
    end else begin
      ef = eflags; wt = wtally; nt = ntally; pbl = pleft;
      if (ef == 3'd0) begin
        if (ty == TYPE_UPDATE) begin
          if (off == 17'd0) wlen_next = {b, 8'd0};
          else if (off == 17'd1) begin
            wlen_next = {wlen[15:8], b};
            if ({1'b0, wlen[15:8], b} + 17'd4 > pl) ef = ST_OVERRUN;
          end else if (off < wrl + 17'd2 || off >= wrl + tpal + 17'd4 && off > wrl + 17'd3) begin
            if (pbl != '0) pbl = pbl - 1'b1;
            else begin
              if (off < wrl + 17'd2) wt = wt + 16'd1; else nt = nt + 16'd1;
              if (32'(b) > MAX_PREFIX_BITS) ef = ST_BAD_PREFIX;
              else pbl = PBW'((9'(b) + 9'd7) >> 3);
            end
          end else if (off == wrl + 17'd2) begin
            if (pbl != '0) ef = ST_BAD_PREFIX;
            alen_next = {b, 8'd0};
          end else if (off == wrl + 17'd3) begin
            alen_next = {alen[15:8], b};
            if ({1'b0, wrl} + {1'b0, alen[15:8], b} + 18'd4 > {1'b0, pl}) ef = ST_OVERRUN;
          end
        end else if (ty == TYPE_OPEN) begin
          if (off == 17'd0) begin
            if (b != 8'd4) ef = ST_BAD_VERSION;
          end else if (off <= 17'd8) ofields_next[(8 - off[3:0]) * 8 +: 8] = b;
          else if (off == 17'd9) begin
            if (17'd10 + 17'(b) > pl) ef = ST_OVERRUN;
          end
        end else if (ty == TYPE_NOTIFICATION) begin
          if (off == 17'd0) ofields_next[15:8] = b;
          else if (off == 17'd1) ofields_next[7:0] = b;
        end
      end
      wtally_next = wt; ntally_next = nt; pleft_next = pbl; eflags_next = ef;
      pos_next = pos + 16'd1;
      if (pos_next >= dlen) begin
        if (ty == TYPE_UPDATE) begin
          if (pl < 17'd2 && ef == 3'd0) ef = ST_OVERRUN;
          if (pbl != '0 && ef == 3'd0) ef = ST_BAD_PREFIX;
        end else if (ty == TYPE_OPEN) begin
          if (pl < 17'd10 && ef == 3'd0) ef = ST_OVERRUN;
        end else if (ty == TYPE_NOTIFICATION) begin
          if (pl < 17'd2 && ef == 3'd0) ef = ST_OVERRUN;
        end
        emit = 1'b1; clr = 1'b1;
        res = build(ef, 1'b1, 1'b1, ty, dlen, wt, alen_next, nt, ofields_next);
      end
    end
    if (clr) begin
      phase_next = 1'b0; pos_next = '0; dlen_next = '0; wlen_next = '0; alen_next = '0;
      wtally_next = '0; ntally_next = '0; ty_next = '0; pleft_next = '0;
      ofields_next = '0; eflags_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop && emit) out_data <= res;
    if (rst) begin
      phase <= 1'b0; pos <= '0; dlen <= '0; wlen <= '0; alen <= '0; wtally <= '0;
      ntally <= '0; ty <= '0; pleft <= '0; ofields <= '0; eflags <= '0;
      halted <= 1'b0; out_valid <= 1'b0;
    end else begin
      if (out_ready) out_valid <= 1'b0;
      if (q_pop) begin
        phase <= phase_next; pos <= pos_next; dlen <= dlen_next; wlen <= wlen_next;
        alen <= alen_next; wtally <= wtally_next; ntally <= ntally_next; ty <= ty_next;
        pleft <= pleft_next; ofields <= ofields_next; eflags <= eflags_next;
        halted <= halted_next;
        if (emit) out_valid <= 1'b1;
      end
    end
  end
endmodule

/* rtl/bgp_message_stream_parser.sv */
// BGP byte stream parser: usage
// channel in: one transfer per stream byte (req_type 0) or end of stream
//   (req_type 1); channel out: one summary transfer per finished message and per end of stream.
// throughput: one input transfer per cycle sustained while out is not held;
//   the back part handles one queued byte per cycle with its running counters.
// output: the byte ending the message is first written into the queue; out.valid
//   rises at the edge that pops it from the queue into the result register.
// reset: synchronous rst clears the parse state, queue and output valid.
// stall: while out is held, the result register keeps its item, the back
//   part stops, the two-entry queue fills and then in_ready drops.
// a bad marker gives one result and halts the block; afterwards every
//   input transfer is accepted and dropped until reset.
// MAX_PREFIX_BITS sets the largest prefix length accepted (32 to 128).
module bgp_message_stream_parser import bmp_pkg::*; #(
  parameter int MAX_PREFIX_BITS = 32
) (
  input logic clk,
  input logic rst,
  bmp_stream_if.sink   in,
  bmp_stream_if.source out
);
  logic q_push, q_full, q_pop, q_ne, halted;
  in_item_t q_in, q_out;
  out_item_t od;
  bmp_front u_front (.in_valid(in.valid), .in_ready(in.ready),
    .in_data(in.data), .q_push, .q_data(q_in), .q_full, .halted);
  bmp_queue u_queue (.clk, .rst, .push(q_push), .push_data(q_in), .full(q_full),
    .pop(q_pop), .nonempty(q_ne), .pop_data(q_out));
  bmp_back #(.MAX_PREFIX_BITS(MAX_PREFIX_BITS)) u_back (.clk, .rst,
    .q_nonempty(q_ne), .q_data(q_out), .q_pop, .halted, .out_valid(out.valid),
    .out_ready(out.ready), .out_data(od));
  assign out.data = od;
endmodule

/* rtl/bmp_checker.sv */
// port-level checks on the parser, bound to the top level
// depends on bmp_pkg and the defines header
`include "bgp_message_stream_parser_defines.svh"
module bmp_checker import bmp_pkg::*; (
  input logic clk,
  input logic rst,
  input logic out_valid,
  input logic out_ready,
  input logic [2:0] status,
  input logic [7:0] msg_type,
  input logic [15:0] announced_count
);
  `BMP_ASSERT_NEXT(a_hold, clk, rst, out_valid && !out_ready, out_valid && $stable(status))
  `BMP_ASSERT_IMPL(a_idle, clk, rst, out_valid && status == ST_IDLE_END, msg_type == 8'd0)
  `BMP_ASSERT_IMPL(a_marker, clk, rst, out_valid && status == ST_BAD_MARKER, announced_count == 16'd0)
endmodule
bind bgp_message_stream_parser bmp_checker u_chk (.clk, .rst, .out_valid(out.valid),
  .out_ready(out.ready), .status(out.data.status), .msg_type(out.data.msg_type),
  .announced_count(out.data.announced_count));
